// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files of the ratio enumerator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/cpre_pkg.sv =====
// Package: shared types and constants of the ratio enumerator.
`default_nettype none
package cpre_pkg;

    localparam int NUM_W   = 41;  // base + 40-bit prefix
    localparam int Q_W     = 18;  // Q2.16 ratio
    localparam int FRAC_W  = 16;
    localparam int PFX_W   = 40;
    localparam int WORD_W  = 32;

    localparam logic [Q_W-1:0] RATIO_MAX = {Q_W{1'b1}};

    // Configuration register indexes
    localparam logic [1:0] CFG_LIST_COUNT = 2'd0;
    localparam logic [1:0] CFG_BASE_SUM   = 2'd1;
    localparam logic [1:0] CFG_TOTAL_Y    = 2'd2;

    // Input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_CALC,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

// ===== design/cpre_divider.sv =====
// Bit-serial restoring divider giving a saturated Q2.16 quotient.
`default_nettype none
module cpre_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [cpre_pkg::NUM_W-1:0] num,
    input  wire logic [cpre_pkg::NUM_W-1:0] den,
    output logic [cpre_pkg::Q_W-1:0]        quo,
    output cpre_pkg::div_status_t           status
);
    localparam int N = cpre_pkg::NUM_W;
    localparam int Q = cpre_pkg::Q_W;

    logic [N-1:0] rem_reg;
    logic [Q-1:0] low_reg;
    logic [Q-1:0] q_reg;
    logic         sat_reg;
    logic [4:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [N:0]   trial;
    logic         fits;

    // One quotient bit per cycle: shift in the next dividend bit, try to subtract
    assign trial = {rem_reg, low_reg[Q-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(Q);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient >= 2^18 exactly when num >= 4*den (also covers den == 0)
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= {2'b00, num} >= {den, 2'b00};
            rem_reg <= num >> 2;
            low_reg <= {num[1:0], {cpre_pkg::FRAC_W{1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? N'(trial - {1'b0, den}) : trial[N-1:0];
            low_reg <= {low_reg[Q-2:0], 1'b0};
            q_reg   <= {q_reg[Q-2:0], fits};
        end
    end

    assign quo         = sat_reg ? cpre_pkg::RATIO_MAX : q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

`include "assert_macros.svh"
    `ASSERT_NEXT(a_start_busy, start, busy_reg)
    `ASSERT_IMP(a_done_idle, done_reg, !busy_reg)
    `ASSERT_IMP(a_cnt_live, busy_reg, cnt_reg != 5'd0)

endmodule
`default_nettype wire

// ===== design/cartesian_prefix_ratio_enumerator.sv =====
// Top level: list store, odometer, prefix sums and ratio output of the enumerator.
//
//  channel  | direction | handshake         | contents
//  s_*      | in        | s_tvalid/s_tready | load element or step request
//  m_*      | out       | m_tvalid/m_tready | consistency, coverage, flags, last
//  cfg_*    | in        | cfg_we            | list_count, base_sum, total_y
//
// A step recomputes the prefixes of k lists, from the lowest changed list to the last;
// each list is read from the one-port element memory and then added, and the two
// bit-serial dividers follow. No new input is accepted until the step is done.
// rst_n clears control, lengths, digits and prefixes; the element memory is not cleared.
// A result waits in the output register; the block stalls before loading the
// next one until the previous result has been taken.
`default_nettype none
module cartesian_prefix_ratio_enumerator #(
    parameter int MAX_LISTS    = 8,
    parameter int MAX_LIST_LEN = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] list_index, [6:3] elem_index, [38:7] x_value, [70:39] minxy_value
    input  wire logic [71:0] s_tdata,
    // [0] opcode
    input  wire logic        s_tuser,
    // is_last_elem
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [17:0] consistency, [35:18] coverage
    output logic [39:0]      m_tdata,
    // [1:0] zero_divisor
    output logic [1:0]       m_tuser,
    // last
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int LIST_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int CNT_W  = $clog2(MAX_LISTS + 1);
    localparam int ELEM_W = $clog2(MAX_LIST_LEN);
    localparam int LEN_W  = $clog2(MAX_LIST_LEN + 1);
    localparam int DEPTH  = MAX_LISTS * MAX_LIST_LEN;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = cpre_pkg::PFX_W;
    localparam int NW     = cpre_pkg::NUM_W;
    localparam int WW     = cpre_pkg::WORD_W;

    cpre_pkg::state_t state_reg, state_next;

    // Configuration
    logic [3:0]    list_count_reg;
    logic [WW-1:0] base_sum_reg;
    logic [WW-1:0] total_y_reg;

    // Odometer and prefix state
    logic [LEN_W-1:0]  len_reg   [MAX_LISTS];
    logic [ELEM_W-1:0] digit_reg [MAX_LISTS];
    logic [PW-1:0]     pfx_x_reg [MAX_LISTS];
    logic [PW-1:0]     pfx_m_reg [MAX_LISTS];
    logic [LIST_W-1:0] fcl_reg;
    logic [LIST_W-1:0] ch_reg;
    logic [PW-1:0]     acc_x_reg;
    logic [PW-1:0]     acc_m_reg;
    logic [1:0]        flags_reg;
    logic              last_reg;

    // Element memory: {minxy, x}
    logic [2*WW-1:0] store_mem [DEPTH];
    logic [2*WW-1:0] rd_data_reg;

    // Output register
    logic                   m_valid_reg;
    logic [cpre_pkg::Q_W-1:0] cons_out_reg, cov_out_reg;
    logic [1:0]             flags_out_reg;
    logic                   last_out_reg;

    // Input fields
    logic [2:0]  in_li;
    logic [3:0]  in_ei;
    logic [31:0] in_x, in_m;
    assign in_li = s_tdata[2:0];
    assign in_ei = s_tdata[6:3];
    assign in_x  = s_tdata[38:7];
    assign in_m  = s_tdata[70:39];

    logic s_xfer, load_xfer, step_xfer, load_ok;
    assign s_xfer    = s_tvalid && s_tready;
    assign load_xfer = s_xfer && (s_tuser == cpre_pkg::OP_LOAD);
    assign step_xfer = s_xfer && (s_tuser == cpre_pkg::OP_STEP);
    assign load_ok   = (int'(in_li) < MAX_LISTS) && (int'(in_ei) < MAX_LIST_LEN);

    // Lists in use, clamped to 1..MAX_LISTS
    logic [CNT_W-1:0] lists_n;
    always_comb
    begin
        priority if (list_count_reg == 4'd0)
            lists_n = CNT_W'(1);
        else if (int'(list_count_reg) > MAX_LISTS)
            lists_n = CNT_W'(MAX_LISTS);
        else
            lists_n = CNT_W'(list_count_reg);
    end

    logic [LIST_W-1:0] start_ch;
    logic              ch_at_end;
    assign start_ch  = (CNT_W'(fcl_reg) >= lists_n) ? '0 : fcl_reg;
    assign ch_at_end = (CNT_W'(ch_reg) + CNT_W'(1)) == lists_n;

    logic [ADDR_W-1:0] wr_addr, rd_addr;
    assign wr_addr = ADDR_W'(LIST_W'(in_li)) * ADDR_W'(MAX_LIST_LEN) + ADDR_W'(in_ei);
    assign rd_addr = ADDR_W'(ch_reg) * ADDR_W'(MAX_LIST_LEN) + ADDR_W'(digit_reg[ch_reg]);

    // Prefix update for the current list
    logic [PW-1:0] sum_x, sum_m;
    assign sum_x = acc_x_reg + PW'(rd_data_reg[WW-1:0]);
    assign sum_m = acc_m_reg + PW'(rd_data_reg[2*WW-1:WW]);

    // Ratio operands
    logic [NW-1:0] num, den_cons, den_cov;
    assign num      = NW'(base_sum_reg) + NW'(acc_m_reg);
    assign den_cons = NW'(base_sum_reg) + NW'(acc_x_reg);
    assign den_cov  = NW'(total_y_reg);

    // Odometer carry: last list fastest, carry moves toward list 0
    logic [MAX_LISTS-1:0] cin;
    logic                 all_wrap;
    logic [LIST_W-1:0]    new_fcl;
    always_comb
    begin
        logic carry;
        carry   = 1'b1;
        new_fcl = '0;
        for (int i = MAX_LISTS - 1; i >= 0; i--)
        begin
            if (CNT_W'(i) < lists_n)
            begin
                cin[i] = carry;
                carry  = carry &&
                    ((LEN_W'(digit_reg[i]) + LEN_W'(1)) == len_reg[i]);
            end
            else
            begin
                cin[i] = 1'b0;
            end
            if (cin[i])
                new_fcl = LIST_W'(i);
        end
        all_wrap = carry;
    end

    // Dividers
    logic                     div_start;
    logic [cpre_pkg::Q_W-1:0] cons_q, cov_q;
    cpre_pkg::div_status_t    cons_st, cov_st;

    cpre_divider u_div_cons (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num),
        .den    (den_cons),
        .quo    (cons_q),
        .status (cons_st)
    );

    cpre_divider u_div_cov (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num),
        .den    (den_cov),
        .quo    (cov_q),
        .status (cov_st)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpre_pkg::ST_IDLE:   if (step_xfer) state_next = cpre_pkg::ST_READ;
            cpre_pkg::ST_READ:   state_next = cpre_pkg::ST_SUM;
            cpre_pkg::ST_SUM:    state_next = ch_at_end ? cpre_pkg::ST_CALC : cpre_pkg::ST_READ;
            cpre_pkg::ST_CALC:   state_next = cpre_pkg::ST_DIV;
            cpre_pkg::ST_DIV:    if (cons_st.done) state_next = cpre_pkg::ST_FINISH;
            cpre_pkg::ST_FINISH: if (out_free) state_next = cpre_pkg::ST_IDLE;
            default:             state_next = cpre_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            cpre_pkg::ST_IDLE: s_tready  = 1'b1;
            cpre_pkg::ST_CALC: div_start = 1'b1;
            default:           ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cpre_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration, lengths, digits, prefixes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_count_reg <= 4'd1;
            base_sum_reg   <= '0;
            total_y_reg    <= '0;
            fcl_reg        <= '0;
            for (int i = 0; i < MAX_LISTS; i++)
            begin
                len_reg[i]   <= LEN_W'(1);
                digit_reg[i] <= '0;
                pfx_x_reg[i] <= '0;
                pfx_m_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cpre_pkg::CFG_LIST_COUNT:
                    begin
                        list_count_reg <= cfg_data[3:0];
                        fcl_reg        <= '0;
                        for (int i = 0; i < MAX_LISTS; i++)
                            digit_reg[i] <= '0;
                    end
                    cpre_pkg::CFG_BASE_SUM: base_sum_reg <= cfg_data;
                    cpre_pkg::CFG_TOTAL_Y:  total_y_reg  <= cfg_data;
                    default:                ;
                endcase
            end

            if (load_xfer)
            begin
                if (load_ok && s_tlast)
                    len_reg[LIST_W'(in_li)] <= LEN_W'(in_ei) + LEN_W'(1);
                fcl_reg <= '0;
                for (int i = 0; i < MAX_LISTS; i++)
                    digit_reg[i] <= '0;
            end

            if (state_reg == cpre_pkg::ST_SUM)
            begin
                pfx_x_reg[ch_reg] <= sum_x;
                pfx_m_reg[ch_reg] <= sum_m;
            end

            if (state_reg == cpre_pkg::ST_CALC)
            begin
                fcl_reg <= all_wrap ? '0 : new_fcl;
                for (int i = 0; i < MAX_LISTS; i++)
                begin
                    if (all_wrap)
                        digit_reg[i] <= '0;
                    else if (cin[i])
                        digit_reg[i] <=
                            ((LEN_W'(digit_reg[i]) + LEN_W'(1)) == len_reg[i])
                            ? '0 : digit_reg[i] + ELEM_W'(1);
                end
            end
        end
    end

    // Element memory
    always_ff @(posedge clk)
    begin
        if (load_xfer && load_ok)
            store_mem[wr_addr] <= {in_m, in_x};
        if (state_reg == cpre_pkg::ST_READ)
            rd_data_reg <= store_mem[rd_addr];
    end

    // Prefix walk and result capture
    always_ff @(posedge clk)
    begin
        if (step_xfer)
        begin
            ch_reg    <= start_ch;
            acc_x_reg <= (start_ch == '0) ? '0 : pfx_x_reg[start_ch - LIST_W'(1)];
            acc_m_reg <= (start_ch == '0) ? '0 : pfx_m_reg[start_ch - LIST_W'(1)];
        end
        if (state_reg == cpre_pkg::ST_SUM)
        begin
            acc_x_reg <= sum_x;
            acc_m_reg <= sum_m;
            if (!ch_at_end)
                ch_reg <= ch_reg + LIST_W'(1);
        end
        if (state_reg == cpre_pkg::ST_CALC)
        begin
            flags_reg <= {total_y_reg == '0, den_cons == '0};
            last_reg  <= all_wrap;
        end
        if ((state_reg == cpre_pkg::ST_FINISH) && out_free)
        begin
            cons_out_reg  <= cons_q;
            cov_out_reg   <= cov_q;
            flags_out_reg <= flags_reg;
            last_out_reg  <= last_reg;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if ((state_reg == cpre_pkg::ST_FINISH) && out_free)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, cov_out_reg, cons_out_reg};
    assign m_tuser  = flags_out_reg;
    assign m_tlast  = last_out_reg;

`include "assert_macros.svh"
    `ASSERT_NEXT(a_step_blocks, step_xfer, !s_tready)
    `ASSERT_IMP(a_div_pair, cons_st.done || cov_st.done, cons_st.done && cov_st.done)
    `ASSERT_IMP(a_div_in_div, cons_st.busy, state_reg == cpre_pkg::ST_DIV)
    `ASSERT_IMP(a_ch_range, state_reg == cpre_pkg::ST_SUM, CNT_W'(ch_reg) < lists_n)

endmodule
`default_nettype wire
